/* rtl/aes_pkg.sv */
`default_nettype none
package aes_pkg;

	typedef struct packed {
		logic        kind;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_KEY_LENGTH = 3'd0;
	localparam cfg_idx_t REG_KEY_0      = 3'd1;
	localparam cfg_idx_t REG_KEY_1      = 3'd2;
	localparam cfg_idx_t REG_KEY_2      = 3'd3;
	localparam cfg_idx_t REG_KEY_3      = 3'd4;

	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;
	localparam logic [1:0] KLEN_256 = 2'd2;

	// Rounds in the deepest key size; shorter keys bypass the first rounds
	localparam int MAX_ROUNDS = 14;
	localparam int NUM_RKEYS  = MAX_ROUNDS + 1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Byte k of the state sits at bits [127-8k -: 8]
	function automatic logic [7:0] get_b(input logic [127:0] s, input int k);
		get_b = s[127-8*k -: 8];
	endfunction

	function automatic logic [127:0] byte_sub(input logic [127:0] s, input logic inv);
		logic [127:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			r[127-8*k -: 8] = inv ? INV_SBOX[get_b(s, k)] : SBOX[get_b(s, k)];
		end
		byte_sub = r;
	endfunction

	function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
		logic [127:0] r;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int rw = 0; rw < 4; rw++) begin
				if (inv)
					r[127-8*(4*((c+rw)%4)+rw) -: 8] = get_b(s, 4*c+rw);
				else
					r[127-8*(4*c+rw) -: 8] = get_b(s, 4*((c+rw)%4)+rw);
			end
		end
		row_rotate = r;
	endfunction

	function automatic logic [127:0] col_mix(input logic [127:0] s, input logic inv);
		logic [127:0] r;
		logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, u, v;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
			a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
			// Inverse = forward after a premix with {04}/{05} terms
			if (inv) begin
				u = xtime(xtime(a0 ^ a2));
				v = xtime(xtime(a1 ^ a3));
				a0 = a0 ^ u; a2 = a2 ^ u; a1 = a1 ^ v; a3 = a3 ^ v;
			end
			x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
			y0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
			y1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
			y2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
			y3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
			r[127-32*c -: 32] = {y0, y1, y2, y3};
		end
		col_mix = r;
	endfunction

endpackage
`default_nettype wire

/* rtl/aes_key_sched.sv */
`default_nettype none
// Expand the configured key one word per cycle after reset and after each restart
module aes_key_sched (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         restart,
	input  wire logic [1:0]   key_length,
	input  wire logic [255:0] key,
	output logic [127:0]      rkey [aes_pkg::NUM_RKEYS],
	output logic              busy
);

	localparam int WCNT = 4 * aes_pkg::NUM_RKEYS;

	logic [31:0] w_q [WCNT];
	logic [5:0]  idx_q;
	logic [7:0]  rcon_q;
	logic [3:0]  nk;
	logic [2:0]  pos_q;
	logic        run_q;
	logic [31:0] t, t_rot, w_new;
	logic [5:0]  src_idx;

	assign nk = (key_length == aes_pkg::KLEN_128) ? 4'd4 :
	            (key_length == aes_pkg::KLEN_192) ? 4'd6 : 4'd8;
	assign busy = run_q;

	assign src_idx = idx_q - {2'd0, nk};
	assign t_rot = {w_q[idx_q - 6'd1][23:0], w_q[idx_q - 6'd1][31:24]};

	// Compute the next expanded word
	always_comb begin
		t = w_q[idx_q - 6'd1];
		if (pos_q == 3'd0)
			t = aes_pkg::sub_word(t_rot) ^ {rcon_q, 24'd0};
		else if (nk == 4'd8 && pos_q == 3'd4)
			t = aes_pkg::sub_word(t);
		w_new = w_q[src_idx] ^ t;
	end

	// Load key words and advance one word a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b1;
			idx_q  <= 6'd0;
			pos_q  <= 3'd0;
			rcon_q <= 8'h01;
		end else if (restart || (idx_q == 6'd0 && run_q)) begin
			run_q  <= 1'b1;
			idx_q  <= {2'd0, nk};
			pos_q  <= 3'd0;
			rcon_q <= 8'h01;
		end else if (run_q) begin
			if (idx_q == 6'(WCNT - 1)) run_q <= 1'b0;
			idx_q <= idx_q + 6'd1;
			if (pos_q == 3'(nk - 4'd1)) begin
				pos_q  <= 3'd0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
			if (pos_q == 3'd0) rcon_q <= aes_pkg::xtime(rcon_q);
		end
	end

	always_ff @(posedge clk) begin
		if (restart || (idx_q == 6'd0 && run_q)) begin
			for (int i = 0; i < 8; i++) w_q[i] <= key[255-32*i -: 32];
		end else if (run_q) begin
			w_q[idx_q] <= w_new;
		end
	end

	// Round key r is entry r; shorter keys leave the top entries unused
	always_comb begin
		for (int r = 0; r < aes_pkg::NUM_RKEYS; r++) begin
			rkey[r] = {w_q[4*r], w_q[4*r+1], w_q[4*r+2], w_q[4*r+3]};
		end
	end

endmodule
`default_nettype wire

/* rtl/aes_round.sv */
`default_nettype none
// One registered round stage, encrypt or decrypt form, or a pass-through when inactive
module aes_round (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         vld_in,
	input  wire logic         dec_in,
	input  wire logic         act_in,
	input  wire logic         last_in,
	input  wire logic [127:0] st_in,
	input  wire logic [127:0] rk,
	output logic              vld_s1,
	output logic              dec_s1,
	output logic [127:0]      st_s1
);

	logic [127:0] enc_v, dec_v, nxt;

	always_comb begin
		enc_v = aes_pkg::row_rotate(aes_pkg::byte_sub(st_in, 1'b0), 1'b0);
		if (!last_in) enc_v = aes_pkg::col_mix(enc_v, 1'b0);
		enc_v = enc_v ^ rk;
		dec_v = aes_pkg::byte_sub(aes_pkg::row_rotate(st_in, 1'b1), 1'b1) ^ rk;
		if (!last_in) dec_v = aes_pkg::col_mix(dec_v, 1'b1);
		nxt = !act_in ? st_in : (dec_in ? dec_v : enc_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1  <= nxt;
			dec_s1 <= dec_in;
		end
	end

endmodule
`default_nettype wire

/* rtl/aes_block_cipher.sv */
`default_nettype none
// Channel  | valid      | stall      | payload
// in       | in_valid   | in_stall   | in_item  (aes_pkg::in_item_t)
// out      | out_valid  | out_stall  | out_item (aes_pkg::out_item_t)
// cfg      | cfg_we     | -          | cfg_index, cfg_data
//
// A whitening stage and 14 round stages, each one register; the last round
// register drives out. One block enters per cycle while in is not stalled.
// Shorter keys pass the first 2 or 4 round stages untouched.
// After reset or a key write the schedule runs while input is stalled.
// A stall on out with out_valid high freezes the whole pipeline; nothing is dropped.
module aes_block_cipher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [63:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire aes_pkg::in_item_t   in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output aes_pkg::out_item_t       out_item
);

	localparam int NR = aes_pkg::MAX_ROUNDS;

	logic [1:0]   klen_q;
	logic [255:0] key_q;
	logic         ks_restart_q;
	logic [127:0] rkey [aes_pkg::NUM_RKEYS];
	logic         ks_busy;
	logic         adv;
	logic [3:0]   first;

	logic         vld_p [NR+1];
	logic         dec_p [NR+1];
	logic [127:0] st_p  [NR+1];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= 2'd0;
			key_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aes_pkg::REG_KEY_LENGTH: klen_q <= cfg_data[1:0];
				aes_pkg::REG_KEY_0:      key_q[255:192] <= cfg_data;
				aes_pkg::REG_KEY_1:      key_q[191:128] <= cfg_data;
				aes_pkg::REG_KEY_2:      key_q[127:64]  <= cfg_data;
				aes_pkg::REG_KEY_3:      key_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Restart the schedule once the written value sits in the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ks_restart_q <= 1'b0;
		else ks_restart_q <= cfg_we;
	end

	aes_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .restart(ks_restart_q), .key_length(klen_q),
		.key(key_q), .rkey(rkey), .busy(ks_busy)
	);

	// Whole pipeline advances unless the output is held
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv || ks_busy || cfg_we || ks_restart_q;

	// Bypassed round stages (first active is first + 1): 4 for 128, 2 for 192, 0 for 256
	assign first = (klen_q == aes_pkg::KLEN_128) ? 4'd4 :
	               (klen_q == aes_pkg::KLEN_192) ? 4'd2 : 4'd0;

	// Round keys by pipeline stage: encrypt uses key (stage - first),
	// decrypt uses key nr - that, with nr = NR - first
	function automatic logic [127:0] key_for(input int stg, input logic dec,
	                                         input logic [3:0] f);
		logic [3:0] k;
		k = 4'(stg) - f;
		key_for = dec ? rkey[4'(NR) - f - k] : rkey[k];
	endfunction

	// Whitening stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p[0] <= 1'b0;
		else if (adv) vld_p[0] <= in_valid && !in_stall;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_p[0]  <= {in_item.block_high, in_item.block_low} ^
			            key_for(0 + 32'(first), in_item.kind, first);
			dec_p[0] <= in_item.kind;
		end
	end

	for (genvar g = 1; g <= NR; g++) begin : g_rnd
		aes_round u_rnd (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(vld_p[g-1]), .dec_in(dec_p[g-1]),
			.act_in(4'(g) > first), .last_in(g == NR),
			.st_in(st_p[g-1]),
			.rk(key_for(g, dec_p[g-1], first)),
			.vld_s1(vld_p[g]), .dec_s1(dec_p[g]), .st_s1(st_p[g])
		);
	end

	assign out_valid = vld_p[NR];
	assign out_item  = {st_p[NR][127:64], st_p[NR][63:0]};

`ifndef SYNTHESIS
	a_no_in_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ks_busy |-> in_stall) else $error("input taken during key expansion");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("held result changed");
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_p[NR-1]) |=> out_valid) else $error("item lost in last stage");
`endif

endmodule
`default_nettype wire
